### rtl/sccb_pkg.sv
// Shared types and constants for the SCCB register master.
package sccb_pkg;

  localparam int unsigned TicksWidth = 16;
  localparam logic [TicksWidth-1:0] TicksReset = 16'd100;

  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] READ_BIT_MASK = 8'h01;
  localparam logic [7:0] MSB_MASK      = 8'h80;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] device_id;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_level;
  } req_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       dont_care_error;
    logic       na_error;
  } res_t;

endpackage

### rtl/sccb_req_if.sv
// Request channel: one beat is one bus tick with an optional new request.
interface sccb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] device_id;
  logic [7:0] register_address;
  logic [7:0] write_data;
  logic       sda_level;

  modport source (
    output valid, command, device_id, register_address, write_data, sda_level,
    input  ready
  );
  modport sink (
    input  valid, command, device_id, register_address, write_data, sda_level,
    output ready
  );
endinterface

### rtl/sccb_res_if.sv
// Result channel: one beat carries the bus line levels and status of one tick.
interface sccb_res_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda_out;
  logic       sda_drive;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       dont_care_error;
  logic       na_error;

  modport source (
    output valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
           dont_care_error, na_error,
    input  ready
  );
  modport sink (
    input  valid, scl, sda_out, sda_drive, busy_res, done_res, read_data,
           dont_care_error, na_error,
    output ready
  );
endinterface

### rtl/sccb_seq.sv
// Bus phase sequencer: advances the SCCB transaction by one tick per step.
module sccb_seq #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                step_i,
  input  sccb_pkg::req_t                      req_i,
  input  logic [sccb_pkg::TicksWidth-1:0]     ticks_i,
  output sccb_pkg::res_t                      res_o
);
  import sccb_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST0  = 5'd1,
    PH_ST1  = 5'd2,
    PH_ST2  = 5'd3,
    PH_WB0  = 5'd4,
    PH_WB1  = 5'd5,
    PH_WB2  = 5'd6,
    PH_WA0  = 5'd7,
    PH_WA1  = 5'd8,
    PH_WA2  = 5'd9,
    PH_RB0  = 5'd10,
    PH_RB1  = 5'd11,
    PH_RB2  = 5'd12,
    PH_RN0  = 5'd13,
    PH_RN1  = 5'd14,
    PH_RN2  = 5'd15,
    PH_SP0  = 5'd16,
    PH_SP1  = 5'd17,
    PH_SP2  = 5'd18
  } phase_e;

  localparam logic [32:0] DelayMax = (33'd1 << DELAY_WIDTH) - 33'd1;

  phase_e                 phase_q, phase_d;
  logic [DELAY_WIDTH-1:0] count_q, count_d;
  logic [3:0]             bit_q, bit_d;
  logic [2:0]             byte_q, byte_d;
  logic                   is_read_q, is_read_d;
  logic [7:0]             shift_q, shift_d;
  logic [7:0]             id_q, id_d;
  logic [7:0]             addr_q, addr_d;
  logic [7:0]             data_q, data_d;
  logic [7:0]             recv_q, recv_d;
  logic [1:0]             err_q, err_d;

  logic [32:0] dly_eff;
  logic [32:0] count_inc;

  // Byte that goes out in the current write slot.
  function automatic logic [7:0] slot_byte(input logic [2:0] idx, input logic rd,
                                            input logic [7:0] id, input logic [7:0] addr,
                                            input logic [7:0] data);
    logic [7:0] b;
    if (idx == 3'd0) begin
      b = id;
    end else if (idx == 3'd1) begin
      b = addr;
    end else if (rd) begin
      b = id | READ_BIT_MASK;
    end else begin
      b = data;
    end
    return b;
  endfunction

  always_comb begin
    if (ticks_i == '0) begin
      dly_eff = 33'd1;
    end else if (33'(ticks_i) > DelayMax) begin
      dly_eff = DelayMax;
    end else begin
      dly_eff = 33'(ticks_i);
    end
  end

  always_comb begin
    phase_d   = phase_q;
    count_d   = count_q;
    bit_d     = bit_q;
    byte_d    = byte_q;
    is_read_d = is_read_q;
    shift_d   = shift_q;
    id_d      = id_q;
    addr_d    = addr_q;
    data_d    = data_q;
    recv_d    = recv_q;
    err_d     = err_q;
    count_inc = '0;

    res_o.scl       = 1'b1;
    res_o.sda_out   = 1'b1;
    res_o.sda_drive = 1'b1;
    res_o.busy_res  = 1'b0;
    res_o.done_res  = 1'b0;

    if (step_i) begin
      if (phase_q == PH_IDLE &&
          (req_i.command == CMD_WRITE || req_i.command == CMD_READ)) begin
        id_d      = req_i.device_id;
        addr_d    = req_i.register_address;
        data_d    = req_i.write_data;
        is_read_d = (req_i.command == CMD_READ);
        err_d     = '0;
        byte_d    = '0;
        bit_d     = '0;
        count_d   = '0;
        phase_d   = PH_ST0;
      end

      if (phase_d != PH_IDLE) begin
        res_o.busy_res = 1'b1;
        case (phase_d)
          PH_ST0: begin
            res_o.scl = 1'b1; res_o.sda_out = 1'b1;
          end
          PH_ST1, PH_SP1: begin
            res_o.scl = 1'b1; res_o.sda_out = 1'b0;
          end
          PH_ST2, PH_SP0: begin
            res_o.scl = 1'b0; res_o.sda_out = 1'b0;
          end
          PH_WB0, PH_WB2: begin
            res_o.scl = 1'b0; res_o.sda_out = |(shift_d & MSB_MASK);
          end
          PH_WB1: begin
            res_o.scl = 1'b1; res_o.sda_out = |(shift_d & MSB_MASK);
          end
          PH_WA1, PH_RB1, PH_RN1: begin
            res_o.scl = 1'b1; res_o.sda_drive = 1'b0;
          end
          PH_WA0, PH_WA2, PH_RB0, PH_RB2, PH_RN0, PH_RN2: begin
            res_o.scl = 1'b0; res_o.sda_drive = 1'b0;
          end
          default: begin
            res_o.scl = 1'b1; res_o.sda_out = 1'b1;
          end
        endcase

        // Samples are taken on the first tick of a clock-high segment.
        if (count_d == '0) begin
          if (phase_d == PH_WA1 && req_i.sda_level) err_d[0] = 1'b1;
          if (phase_d == PH_RB1) shift_d = {shift_d[6:0], req_i.sda_level};
          if (phase_d == PH_RN1 && !req_i.sda_level) err_d[1] = 1'b1;
        end

        count_inc = 33'(count_d) + 33'd1;
        if (count_inc >= dly_eff) begin
          count_d = '0;
          case (phase_d)
            PH_ST0: phase_d = PH_ST1;
            PH_ST1: phase_d = PH_ST2;
            PH_ST2: begin
              shift_d = slot_byte(byte_d, is_read_d, id_d, addr_d, data_d);
              bit_d   = '0;
              phase_d = PH_WB0;
            end
            PH_WB0: phase_d = PH_WB1;
            PH_WB1: phase_d = PH_WB2;
            PH_WB2: begin
              shift_d = {shift_d[6:0], 1'b0};
              bit_d   = bit_d + 4'd1;
              phase_d = (bit_d >= 4'd8) ? PH_WA0 : PH_WB0;
            end
            PH_WA0: phase_d = PH_WA1;
            PH_WA1: phase_d = PH_WA2;
            PH_WA2: begin
              byte_d = byte_d + 3'd1;
              if (!is_read_d) begin
                if (byte_d >= 3'd3) begin
                  phase_d = PH_SP0;
                end else begin
                  shift_d = slot_byte(byte_d, is_read_d, id_d, addr_d, data_d);
                  bit_d   = '0;
                  phase_d = PH_WB0;
                end
              end else if (byte_d == 3'd1) begin
                shift_d = slot_byte(byte_d, is_read_d, id_d, addr_d, data_d);
                bit_d   = '0;
                phase_d = PH_WB0;
              end else if (byte_d == 3'd2) begin
                phase_d = PH_SP0;
              end else begin
                shift_d = '0;
                bit_d   = '0;
                phase_d = PH_RB0;
              end
            end
            PH_RB0: phase_d = PH_RB1;
            PH_RB1: phase_d = PH_RB2;
            PH_RB2: begin
              bit_d   = bit_d + 4'd1;
              phase_d = (bit_d >= 4'd8) ? PH_RN0 : PH_RB0;
            end
            PH_RN0: phase_d = PH_RN1;
            PH_RN1: phase_d = PH_RN2;
            PH_RN2: begin
              byte_d  = 3'd4;
              phase_d = PH_SP0;
            end
            PH_SP0: phase_d = PH_SP1;
            PH_SP1: phase_d = PH_SP2;
            PH_SP2: begin
              // The stop after the address phase of a read leads to a repeated start.
              if (is_read_d && byte_d == 3'd2) begin
                phase_d = PH_ST0;
              end else begin
                if (is_read_d) recv_d = shift_d;
                phase_d        = PH_IDLE;
                res_o.done_res = 1'b1;
              end
            end
            default: begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
            end
          endcase
        end else begin
          count_d = count_inc[DELAY_WIDTH-1:0];
        end
      end
    end

    res_o.read_data       = recv_d;
    res_o.dont_care_error = err_d[0];
    res_o.na_error        = err_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      count_q   <= '0;
      bit_q     <= '0;
      byte_q    <= '0;
      is_read_q <= 1'b0;
      shift_q   <= '0;
      id_q      <= '0;
      addr_q    <= '0;
      data_q    <= '0;
      recv_q    <= '0;
      err_q     <= '0;
    end else begin
      phase_q   <= phase_d;
      count_q   <= count_d;
      bit_q     <= bit_d;
      byte_q    <= byte_d;
      is_read_q <= is_read_d;
      shift_q   <= shift_d;
      id_q      <= id_d;
      addr_q    <= addr_d;
      data_q    <= data_d;
      recv_q    <= recv_d;
      err_q     <= err_d;
    end
  end

endmodule

### rtl/sccb_res_reg.sv
// Result register: holds one finished beat while the sink stalls.
module sccb_res_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  sccb_pkg::res_t data_i,
  output logic           load_ready_o,
  output logic           valid_o,
  input  logic           ready_i,
  output sccb_pkg::res_t data_o
);
  import sccb_pkg::*;

  logic valid_q, valid_d;
  res_t data_q, data_d;

  // A new beat may enter while the register is empty or when the held one leaves in the same cycle.
  assign load_ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

### rtl/sccb_register_master.sv
// SCCB register master: every request beat is one bus tick and yields exactly one
// result beat with the SCL/SDA levels, drive enable and status for that tick. A new
// beat is taken in every cycle while the result register is empty or being drained;
// each result appears in the cycle after its request, held in a single output register.
// A write or read request is started only while no transaction is in progress, and
// every bus segment lasts ticks_q beats (zero counts as one).
module sccb_register_master #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sccb_pkg::TicksWidth-1:0] cfg_wdata_i,
  sccb_req_if.sink                        req_i,
  sccb_res_if.source                      res_o
);
  import sccb_pkg::*;

  logic [TicksWidth-1:0] ticks_q;
  req_t                  req_beat;
  res_t                  step_res;
  res_t                  held_res;
  logic                  load_ready;
  logic                  step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= TicksReset;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_wdata_i;
    end
  end

  assign req_beat = '{
    command:          req_i.command,
    device_id:        req_i.device_id,
    register_address: req_i.register_address,
    write_data:       req_i.write_data,
    sda_level:        req_i.sda_level
  };

  assign req_i.ready = load_ready;
  assign step        = req_i.valid && load_ready;

  sccb_seq #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .req_i   (req_beat),
    .ticks_i (ticks_q),
    .res_o   (step_res)
  );

  sccb_res_reg u_res_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .data_i       (step_res),
    .load_ready_o (load_ready),
    .valid_o      (res_o.valid),
    .ready_i      (res_o.ready),
    .data_o       (held_res)
  );

  assign res_o.scl             = held_res.scl;
  assign res_o.sda_out         = held_res.sda_out;
  assign res_o.sda_drive       = held_res.sda_drive;
  assign res_o.busy_res        = held_res.busy_res;
  assign res_o.done_res        = held_res.done_res;
  assign res_o.read_data       = held_res.read_data;
  assign res_o.dont_care_error = held_res.dont_care_error;
  assign res_o.na_error        = held_res.na_error;

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_o.valid)
    else $error("accepted request beat produced no result beat");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.done_res |-> res_o.busy_res)
    else $error("done pulse outside a transaction");

  a_idle_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.busy_res |-> res_o.scl && res_o.sda_out && res_o.sda_drive)
    else $error("bus lines not released high while idle");

  a_released_reads_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.sda_drive |-> res_o.sda_out && res_o.busy_res)
    else $error("released data line reported low or outside a transaction");

endmodule
